### hdl/kpm_pkg.sv
// kpm_pkg: shared types, command codes and constants of the keepalive ping monitor.
// Used by every module in hdl/; depends on nothing.
package kpm_pkg;

	localparam int PayloadBytesDefault = 8;

	localparam int CmdW      = 3;
	localparam int ValueW    = 64;
	localparam int LenW      = 7;
	localparam int IntervalW = 32;
	localparam int LimitW    = 16;
	localparam int CfgIndexW = 8;
	localparam int CfgDataW  = 32;
	localparam int InDataW   = 72;
	localparam int OutDataW  = 72;

	localparam logic [IntervalW-1:0] IntervalReset = 32'd1000;
	localparam logic [LimitW-1:0]    LimitReset    = 16'd3;

	localparam logic [CmdW-1:0] CMD_TICK      = 3'd0;
	localparam logic [CmdW-1:0] CMD_WRITE_OK  = 3'd1;
	localparam logic [CmdW-1:0] CMD_WRITE_ERR = 3'd2;
	localparam logic [CmdW-1:0] CMD_PONG      = 3'd3;
	localparam logic [CmdW-1:0] CMD_START     = 3'd4;
	localparam logic [CmdW-1:0] CMD_STOP      = 3'd5;

	localparam logic [CfgIndexW-1:0] REG_INTERVAL = 8'd0;
	localparam logic [CfgIndexW-1:0] REG_RETRY    = 8'd1;

	typedef struct packed {
		logic [CmdW-1:0]   command;
		logic              owner_alive;
		logic [ValueW-1:0] pong_value;
		logic [LenW-1:0]   pong_length;
	} kpm_item_t;

	typedef struct packed {
		logic              send_ping;
		logic [ValueW-1:0] ping_payload;
		logic              failed;
		logic              running;
	} kpm_result_t;

	typedef struct packed {
		logic [IntervalW-1:0] interval_ticks;
		logic [LimitW-1:0]    retry_limit;
	} kpm_cfg_t;

endpackage

### hdl/kpm_cfg_regs.sv
// kpm_cfg_regs: configuration register file (interval and retry limit).
// Depends on kpm_pkg.
module kpm_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kpm_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [kpm_pkg::CfgDataW-1:0]     cfg_data,
	output kpm_pkg::kpm_cfg_t                cfg
);
	import kpm_pkg::*;

	logic [IntervalW-1:0] interval_q;
	logic [LimitW-1:0]    retry_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= IntervalReset;
			retry_q    <= LimitReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INTERVAL: interval_q <= cfg_data[IntervalW-1:0];
				REG_RETRY:    retry_q    <= cfg_data[LimitW-1:0];
				default:      ;  // drop writes to unknown indexes
			endcase
		end
	end

	assign cfg.interval_ticks = interval_q;
	assign cfg.retry_limit    = retry_q;
endmodule

### hdl/kpm_core.sv
// kpm_core: keepalive state registers and the single-pass next-state and result logic.
// Depends on kpm_pkg.
module kpm_core #(
	parameter int PAYLOAD_BYTES = kpm_pkg::PayloadBytesDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  kpm_pkg::kpm_item_t     item,
	input  kpm_pkg::kpm_cfg_t      cfg,
	output kpm_pkg::kpm_result_t   result
);
	import kpm_pkg::*;

	localparam logic [ValueW-1:0] PayloadMask = {ValueW{1'b1}} >> (ValueW - 8*PAYLOAD_BYTES);
	localparam logic [LenW-1:0]   PayloadLen  = LenW'(PAYLOAD_BYTES);

	logic                 active_q, armed_q, awaiting_q;
	logic [IntervalW-1:0] countdown_q;
	logic [ValueW-1:0]    awaited_q, counter_q;
	logic [LimitW-1:0]    tmo_q;

	logic                 active_d, armed_d, awaiting_d;
	logic [IntervalW-1:0] countdown_d;
	logic [ValueW-1:0]    awaited_d, counter_d, counter_inc;
	logic [LimitW-1:0]    tmo_d;

	assign counter_inc = counter_q + 64'd1;

	always_comb begin
		active_d    = active_q;
		armed_d     = armed_q;
		awaiting_d  = awaiting_q;
		countdown_d = countdown_q;
		awaited_d   = awaited_q;
		counter_d   = counter_q;
		tmo_d       = tmo_q;
		result      = '0;
		unique case (item.command)
			CMD_TICK: begin
				if (active_q && armed_q) begin
					if (countdown_q > 32'd1) begin
						countdown_d = countdown_q - 32'd1;
					end else begin
						armed_d     = 1'b0;
						countdown_d = '0;
						if (!item.owner_alive) begin
							active_d   = 1'b0;
							awaiting_d = 1'b0;
							tmo_d      = '0;
						end else if (awaiting_q && tmo_q >= cfg.retry_limit) begin
							active_d      = 1'b0;
							result.failed = 1'b1;
						end else begin
							if (awaiting_q && tmo_q != {LimitW{1'b1}})
								tmo_d = tmo_q + 16'd1;
							counter_d           = counter_inc;
							awaited_d           = counter_inc & PayloadMask;
							awaiting_d          = 1'b1;
							result.send_ping    = 1'b1;
							result.ping_payload = counter_inc & PayloadMask;
						end
					end
				end
			end
			CMD_WRITE_OK: begin
				if (active_q) begin
					armed_d     = 1'b1;
					countdown_d = cfg.interval_ticks;
				end
			end
			CMD_PONG: begin
				if (awaiting_q && item.pong_length == PayloadLen
				    && item.pong_value == awaited_q) begin
					awaiting_d = 1'b0;
					tmo_d      = '0;
				end
			end
			CMD_START: begin
				active_d    = 1'b1;
				armed_d     = 1'b1;
				countdown_d = cfg.interval_ticks;
			end
			CMD_STOP: begin
				active_d    = 1'b0;
				armed_d     = 1'b0;
				countdown_d = '0;
				awaiting_d  = 1'b0;
				tmo_d       = '0;
			end
			default: ;  // write failure and unused codes leave state alone
		endcase
		result.running = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			armed_q     <= 1'b0;
			awaiting_q  <= 1'b0;
			countdown_q <= '0;
			awaited_q   <= '0;
			counter_q   <= '0;
			tmo_q       <= '0;
		end else if (fire) begin
			active_q    <= active_d;
			armed_q     <= armed_d;
			awaiting_q  <= awaiting_d;
			countdown_q <= countdown_d;
			awaited_q   <= awaited_d;
			counter_q   <= counter_d;
			tmo_q       <= tmo_d;
		end
	end
endmodule

### hdl/keepalive_ping_monitor.sv
// Keepalive ping monitor: input register, event logic and result register.
// Input register, then result register; one item per cycle while the output is not stalled.
// A new item is taken while a finished result waits; only a stalled output holds the input.
// The single-pass event logic in kpm_core sets the rate; state updates as each item resolves.
// Active-low async reset clears control state; interval resets to 1000, retry limit to 3.
// Depends on kpm_pkg, kpm_cfg_regs and kpm_core.
module keepalive_ping_monitor #(
	parameter int PAYLOAD_BYTES = kpm_pkg::PayloadBytesDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input item stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata from bit 0: owner_alive[0], pong_value[64:1], pong_length[71:65]
	input  logic [kpm_pkg::InDataW-1:0]   s_axis_tdata,
	// tuser: command[2:0]
	input  logic [kpm_pkg::CmdW-1:0]      s_axis_tuser,
	// Result stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata from bit 0: send_ping[0], ping_payload[64:1], failed[65], running[66], zeros above
	output logic [kpm_pkg::OutDataW-1:0]  m_axis_tdata,
	// Configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kpm_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [kpm_pkg::CfgDataW-1:0]  cfg_data
);
	import kpm_pkg::*;

	kpm_item_t   item_s1;
	logic        valid_s1;
	kpm_result_t result_c;
	kpm_result_t result_s2;
	logic        valid_s2;
	kpm_cfg_t    cfg;
	logic        out_free;
	logic        fire;

	// Result register can take a new result when empty or being drained.
	assign out_free      = !valid_s2 || m_axis_tready;
	// Resolve the held item whenever its result has somewhere to go.
	assign fire          = valid_s1 && out_free;
	// Input register refills in the same cycle it empties.
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Capture the payload; no reset needed on data.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.command     <= s_axis_tuser;
			item_s1.owner_alive <= s_axis_tdata[0];
			item_s1.pong_value  <= s_axis_tdata[64:1];
			item_s1.pong_length <= s_axis_tdata[71:65];
		end
	end

	kpm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kpm_core #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_c)
	);

	// Result register: load on fire, drop the valid once taken with nothing behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result_c;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, result_s2.running, result_s2.failed,
	                        result_s2.ping_payload, result_s2.send_ping};

	// A ping and a failure never come from the same item.
	a_send_xor_fail: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.send_ping && result_s2.failed))
		else $error("ping and failure reported together");

	// A failure always deactivates the block.
	a_fail_stops: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.failed |-> !result_s2.running)
		else $error("failure reported while still running");

	// A ping is only emitted by an active block.
	a_ping_running: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.send_ping |-> result_s2.running)
		else $error("ping emitted while inactive");

	// Payload is zero whenever no ping is sent.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_s2.send_ping |-> result_s2.ping_payload == '0)
		else $error("nonzero payload without ping");

	// A held item is resolved whenever the result register is free.
	a_no_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_free |-> fire)
		else $error("held item not resolved with free output");
endmodule

### tb/sv/testbench.sv
// Self-checking testbench for keepalive_ping_monitor: directed and random commands on the
// input stream, an item-level keepalive predictor, and field-wise checks of every result.
// Depends on kpm_pkg and the keepalive_ping_monitor RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kpm_pkg::*;

	// Command codes the block ignores; they have no name in the package.
	localparam logic [CmdW-1:0] CMD_UNUSED_A = 3'd6;
	localparam logic [CmdW-1:0] CMD_UNUSED_B = 3'd7;

	// Register indexes with no register behind them.
	localparam logic [CfgIndexW-1:0] REG_SPARE_LOW  = 8'd2;
	localparam logic [CfgIndexW-1:0] REG_SPARE_HIGH = 8'hFF;

	localparam int PingBytes = PayloadBytesDefault;
	localparam logic [ValueW-1:0] PingMask =
		(PingBytes >= 8) ? {ValueW{1'b1}} : ((64'd1 << (8 * PingBytes)) - 64'd1);

	localparam int MaxReports  = 10;
	localparam int HoldAt      = 150;   // result count at which the sink holds off
	localparam int HoldCycles  = 300;
	localparam int StallLimit  = 3000;  // cycles with no handshake on any channel

	// One queued command; echo replaces pong_value with the outstanding ping id
	// (xor flip) at the moment the item goes on the bus.
	typedef struct {
		kpm_item_t         item;
		bit                echo;
		logic [ValueW-1:0] flip;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [InDataW-1:0]   s_axis_tdata = '0;
	logic [CmdW-1:0]      s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OutDataW-1:0]  m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;

	keepalive_ping_monitor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the keepalive engine and its registers.
	// ------------------------------------------------------------------
	logic [IntervalW-1:0] ping_interval = IntervalReset;
	logic [LimitW-1:0]    retry_budget  = LimitReset;

	bit                engine_active  = 1'b0;
	bit                timer_running  = 1'b0;
	logic [IntervalW-1:0] ticks_left  = '0;
	bit                pong_pending   = 1'b0;
	logic [ValueW-1:0] expected_pong  = '0;
	logic [LimitW-1:0] missed_pongs   = '0;
	logic [ValueW-1:0] ping_id        = '0;

	stim_t       command_q[$];       // commands waiting to go on the input bus
	kpm_result_t ping_reports_q[$];  // predicted results, oldest first

	bit        idle_on = 1'b1;      // random idling on both sides
	bit        item_offered = 1'b0; // mirrors s_axis_tvalid without the NBA delay
	kpm_item_t shown_item;
	int        in_gap = 0;
	int        failures = 0;
	int        results_seen = 0;

	function automatic void halt_engine();
		engine_active = 1'b0;
		timer_running = 1'b0;
		ticks_left    = '0;
		pong_pending  = 1'b0;
		missed_pongs  = '0;
	endfunction

	// Advance the engine by one command and return the result it produces.
	function automatic kpm_result_t keepalive_step(kpm_item_t ev);
		kpm_result_t r;
		r = '0;
		case (ev.command)
			CMD_TICK: begin
				// Count down only on a live, armed timer; 0 and 1 both expire.
				if (engine_active && timer_running) begin
					if (ticks_left > 32'd1) begin
						ticks_left--;
					end else begin
						timer_running = 1'b0;
						ticks_left    = '0;
						if (!ev.owner_alive) begin
							halt_engine();
						end else if (pong_pending && missed_pongs >= retry_budget) begin
							// Timeout: drop activity, keep the wait and the miss count.
							engine_active = 1'b0;
							r.failed      = 1'b1;
						end else begin
							if (pong_pending && missed_pongs != {LimitW{1'b1}})
								missed_pongs++;
							ping_id++;
							r.ping_payload = ping_id & PingMask;
							expected_pong  = r.ping_payload;
							pong_pending   = 1'b1;
							r.send_ping    = 1'b1;
						end
					end
				end
			end
			CMD_WRITE_OK: begin
				if (engine_active) begin
					timer_running = 1'b1;
					ticks_left    = ping_interval;
				end
			end
			CMD_PONG: begin
				if (pong_pending && ev.pong_length == 7'(PingBytes)
						&& ev.pong_value == expected_pong) begin
					pong_pending = 1'b0;
					missed_pongs = '0;
				end
			end
			CMD_START: begin
				engine_active = 1'b1;
				timer_running = 1'b1;
				ticks_left    = ping_interval;
			end
			CMD_STOP: begin
				halt_engine();
			end
			default: ;
		endcase
		r.running = engine_active;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: predict on every accepted item, then offer the next one or idle.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		stim_t nxt;
		bit    offer;
		if (arst_n) begin
			offer = item_offered;
			if (s_axis_tvalid && s_axis_tready) begin
				ping_reports_q.push_back(keepalive_step(shown_item));
				offer = 1'b0;
			end
			if (!offer) begin
				if (in_gap != 0) begin
					in_gap--;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					// Start an idle burst, this cycle included.
					in_gap = $urandom_range(0, 18);
				end else if (command_q.size() != 0) begin
					nxt = command_q.pop_front();
					shown_item = nxt.item;
					// Answer the outstanding ping; the state is current here since
					// the item just taken was predicted above.
					if (nxt.echo)
						shown_item.pong_value = expected_pong ^ nxt.flip;
					offer = 1'b1;
				end
			end
			item_offered  = offer;
			s_axis_tvalid <= offer;
			s_axis_tdata  <= {shown_item.pong_length, shown_item.pong_value,
				shown_item.owner_alive};
			s_axis_tuser  <= shown_item.command;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result with the oldest prediction, drive tready.
	// ------------------------------------------------------------------
	int  out_stall = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	always @(posedge clk) begin
		kpm_result_t         want;
		logic [OutDataW-1:0] got;
		bit                  ready_next;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				results_seen++;
				if (ping_reports_q.size() == 0) begin
					if (failures < MaxReports)
						$display("result %0d arrived with nothing expected: tdata=%h",
							results_seen, got);
					failures++;
				end else begin
					want = ping_reports_q.pop_front();
					if (got[0] !== want.send_ping || got[64:1] !== want.ping_payload
							|| got[65] !== want.failed || got[66] !== want.running
							|| got[OutDataW-1:67] !== '0) begin
						if (failures < MaxReports)
							$display({"result %0d mismatch: expected send=%0b payload=%h ",
								"failed=%0b running=%0b, got send=%0b payload=%h ",
								"failed=%0b running=%0b pad=%h"}, results_seen,
								want.send_ping, want.ping_payload, want.failed,
								want.running, got[0], got[64:1], got[65], got[66],
								got[OutDataW-1:67]);
						failures++;
					end
				end
			end
			// Hold off once for a long stretch so the block backs up into its input.
			if (hold_left != 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (!hold_done && results_seen == HoldAt) begin
				hold_done  = 1'b1;
				hold_left  = HoldCycles - 1;
				ready_next = 1'b0;
			end else if (out_stall != 0) begin
				out_stall--;
				ready_next = 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_stall  = $urandom_range(0, 18);
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
			end
			m_axis_tready <= ready_next;
		end
	end

	// Watchdog: end the run when no channel has moved anything for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles == StallLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_item(logic [CmdW-1:0] cmd, logic owner, logic [ValueW-1:0] val,
			logic [LenW-1:0] len, bit echo, logic [ValueW-1:0] flip);
		stim_t s;
		s.item.command     = cmd;
		s.item.owner_alive = owner;
		s.item.pong_value  = val;
		s.item.pong_length = len;
		s.echo             = echo;
		s.flip             = flip;
		command_q.push_back(s);
	endtask

	function automatic logic [ValueW-1:0] rand_value();
		return {$urandom, $urandom};
	endfunction

	// Write one register; only called with the block idle.
	task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_INTERVAL)
			ping_interval = val;
		else if (idx == REG_RETRY)
			retry_budget = val[LimitW-1:0];
	endtask

	// Wait until every queued command went in and every result came back.
	task automatic drain_results();
		do @(posedge clk);
		while (command_q.size() != 0 || item_offered || ping_reports_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Queue keepalive sessions (start, ticks to expiry, write outcome, pong) mixed with
	// noise, until about budget commands are queued. span is the programmed interval.
	task automatic queue_sessions(int unsigned span, int unsigned budget);
		int unsigned target;
		int unsigned need;
		int unsigned pick;
		target = command_q.size() + budget;
		while (command_q.size() < target) begin
			if ($urandom_range(0, 9) < 3) begin
				queue_item(CmdW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
					rand_value(), LenW'($urandom_range(0, 125)), 1'b0, '0);
			end else begin
				if ($urandom_range(0, 3) != 0)
					queue_item(CMD_START, 1'($urandom_range(0, 1)), rand_value(),
						LenW'($urandom_range(0, 125)), 1'b0, '0);
				repeat ($urandom_range(1, 4)) begin
					need = (span > 6) ? $urandom_range(1, 6) : ((span < 2) ? 1 : span);
					if ($urandom_range(0, 4) == 0)
						need += $urandom_range(1, 2);
					// Mostly a live owner; now and then it is gone at expiry.
					repeat (need)
						queue_item(CMD_TICK, $urandom_range(0, 24) != 0, rand_value(),
							LenW'($urandom_range(0, 125)), 1'b0, '0);
					pick = $urandom_range(0, 19);
					if (pick < 17)
						queue_item(CMD_WRITE_OK, 1'($urandom_range(0, 1)), rand_value(),
							LenW'($urandom_range(0, 125)), 1'b0, '0);
					else if (pick < 19)
						queue_item(CMD_WRITE_ERR, 1'($urandom_range(0, 1)), rand_value(),
							LenW'($urandom_range(0, 125)), 1'b0, '0);
					pick = $urandom_range(0, 9);
					if (pick < 6)
						queue_item(CMD_PONG, 1'($urandom_range(0, 1)), '0, 7'(PingBytes),
							1'b1, '0);
					else if (pick == 6)
						queue_item(CMD_PONG, 1'($urandom_range(0, 1)), '0,
							($urandom_range(0, 1) != 0) ? 7'(PingBytes - 1)
								: 7'($urandom_range(9, 125)),
							1'b1, '0);
					else if (pick == 7)
						queue_item(CMD_PONG, 1'($urandom_range(0, 1)), '0, 7'(PingBytes),
							1'b1, 64'd1 << $urandom_range(0, 63));
					else if (pick == 8)
						queue_item(CMD_PONG, 1'($urandom_range(0, 1)), rand_value(),
							LenW'($urandom_range(0, 125)), 1'b0, '0);
				end
				if ($urandom_range(0, 7) == 0)
					queue_item(CMD_STOP, 1'($urandom_range(0, 1)), rand_value(),
						LenW'($urandom_range(0, 125)), 1'b0, '0);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers (interval 1000, retry 3): commands on an idle engine,
		// unused codes, a non-expiring tick with a lost owner, restart and stop.
		queue_item(CMD_TICK, 1'b0, '0, '0, 1'b0, '0);
		queue_item(CMD_WRITE_OK, 1'b1, {ValueW{1'b1}}, 7'd125, 1'b0, '0);
		queue_item(CMD_WRITE_ERR, 1'b0, '0, '0, 1'b0, '0);
		queue_item(CMD_PONG, 1'b1, {ValueW{1'b1}}, 7'd125, 1'b0, '0);
		queue_item(CMD_UNUSED_A, 1'b1, rand_value(), 7'd8, 1'b0, '0);
		queue_item(CMD_UNUSED_B, 1'b0, rand_value(), 7'd8, 1'b0, '0);
		queue_item(CMD_START, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_TICK, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_TICK, 1'b0, '0, '0, 1'b0, '0);
		queue_item(CMD_START, 1'b0, '0, '0, 1'b0, '0);
		queue_item(CMD_STOP, 1'b1, '0, '0, 1'b0, '0);
		drain_results();

		// Zero interval, zero retries: pings, bad pongs, timeout failure, the wait kept
		// over a restart, a good pong, stop, a late pong, and a lost owner at expiry.
		write_reg(REG_INTERVAL, 32'd0);
		write_reg(REG_RETRY, 32'd0);
		queue_item(CMD_START, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_TICK, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_PONG, 1'b1, '0, 7'(PingBytes - 1), 1'b1, '0);
		queue_item(CMD_PONG, 1'b1, '0, 7'(PingBytes), 1'b1, 64'h8000_0000_0000_0000);
		queue_item(CMD_WRITE_OK, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_TICK, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_TICK, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_START, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_WRITE_OK, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_PONG, 1'b1, '0, 7'(PingBytes), 1'b1, '0);
		queue_item(CMD_TICK, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_STOP, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_PONG, 1'b1, '0, 7'(PingBytes), 1'b1, '0);
		queue_item(CMD_START, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_TICK, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_WRITE_OK, 1'b1, '0, '0, 1'b0, '0);
		queue_item(CMD_TICK, 1'b0, '0, '0, 1'b0, '0);
		drain_results();

		// Random sessions under several settings; the long sink hold lands in the first.
		write_reg(REG_INTERVAL, 32'd1);
		write_reg(REG_RETRY, 32'd2);
		queue_sessions(1, 180);
		drain_results();

		write_reg(REG_INTERVAL, 32'd0);
		write_reg(REG_RETRY, 32'd0);
		queue_sessions(0, 130);
		drain_results();

		write_reg(REG_INTERVAL, 32'd3);
		write_reg(REG_RETRY, 32'h0000_FFFF);
		queue_sessions(3, 150);
		drain_results();

		// Writes to unmapped indexes must leave both registers alone; the retry
		// write carries junk in its upper half.
		write_reg(REG_INTERVAL, 32'd2);
		write_reg(REG_RETRY, 32'h5A5A_0001);
		write_reg(REG_SPARE_LOW, 32'd7);
		write_reg(REG_SPARE_HIGH, 32'hFFFF_FFFF);
		queue_sessions(2, 130);
		drain_results();

		// Longest interval: ticks only count down.
		write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
		write_reg(REG_RETRY, 32'd3);
		queue_sessions(32'hFFFF_FFFF, 40);
		drain_results();

		// Last stretch at full rate on both sides.
		idle_on = 1'b0;
		write_reg(REG_INTERVAL, 32'd2);
		write_reg(REG_RETRY, 32'd3);
		queue_sessions(2, 200);
		drain_results();

		repeat (8) @(posedge clk);
		if (failures == 0 && ping_reports_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
